>>> hw/rtl/rsfb_pkg.sv
// rsfb_pkg: shared types, constants and checksum function for the radio status frame builder
// no dependencies

package rsfb_pkg;

    localparam int unsigned FRAME_LEN = 17;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [7:0]  FRAME_START  = 8'hFE;
    localparam logic [7:0]  PAYLOAD_LEN  = 8'd9;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] MIN_TX_SPACE = 16'(FRAME_LEN);

    localparam logic [7:0] RST_SOURCE_SYSTEM    = 8'd51;
    localparam logic [7:0] RST_SOURCE_COMPONENT = 8'd68;
    localparam logic [7:0] RST_MESSAGE_ID       = 8'd109;
    localparam logic [7:0] RST_CRC_EXTRA        = 8'd185;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SYSTEM    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COMPONENT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_EXTRA        = 8'd3;

    // frame byte positions
    localparam logic [IDX_W-1:0] IDX_START   = 5'd0;
    localparam logic [IDX_W-1:0] IDX_LEN     = 5'd1;
    localparam logic [IDX_W-1:0] IDX_SEQ     = 5'd2;
    localparam logic [IDX_W-1:0] IDX_SYS     = 5'd3;
    localparam logic [IDX_W-1:0] IDX_COMP    = 5'd4;
    localparam logic [IDX_W-1:0] IDX_MSG     = 5'd5;
    localparam logic [IDX_W-1:0] IDX_RXE_LO  = 5'd6;
    localparam logic [IDX_W-1:0] IDX_RXE_HI  = 5'd7;
    localparam logic [IDX_W-1:0] IDX_COR_LO  = 5'd8;
    localparam logic [IDX_W-1:0] IDX_COR_HI  = 5'd9;
    localparam logic [IDX_W-1:0] IDX_LRSSI   = 5'd10;
    localparam logic [IDX_W-1:0] IDX_RRSSI   = 5'd11;
    localparam logic [IDX_W-1:0] IDX_TXSP    = 5'd12;
    localparam logic [IDX_W-1:0] IDX_LNOISE  = 5'd13;
    localparam logic [IDX_W-1:0] IDX_RNOISE  = 5'd14;
    localparam logic [IDX_W-1:0] IDX_CRC_LO  = 5'd15;
    localparam logic [IDX_W-1:0] IDX_CRC_HI  = 5'd16;

    typedef struct packed {
        logic             load;
        logic             advance;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic short_space;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

>>> hw/rtl/rsfb_if.sv
// rsfb_if: valid/ready channel interfaces for request, frame byte and configuration
// no dependencies

interface rsfb_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] rx_error_count;
    logic [15:0] corrected_count;
    logic [7:0]  local_rssi;
    logic [7:0]  remote_rssi;
    logic [7:0]  local_noise;
    logic [7:0]  remote_noise;
    logic [15:0] tx_space;

    modport source (output valid, rx_error_count, corrected_count, local_rssi, remote_rssi,
                    local_noise, remote_noise, tx_space, input ready);
    modport sink   (input valid, rx_error_count, corrected_count, local_rssi, remote_rssi,
                    local_noise, remote_noise, tx_space, output ready);
endinterface

interface rsfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface rsfb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/rsfb_datapath.sv
// rsfb_datapath: config registers, captured request fields, sequence number and x25 checksum
// depends on rsfb_pkg

module rsfb_datapath
    import rsfb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    output t_dp_status     o_status,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    input  logic [15:0]    i_rx_error_count,
    input  logic [15:0]    i_corrected_count,
    input  logic [7:0]     i_local_rssi,
    input  logic [7:0]     i_remote_rssi,
    input  logic [7:0]     i_local_noise,
    input  logic [7:0]     i_remote_noise,
    input  logic [15:0]    i_tx_space,
    output logic [7:0]     o_out_byte,
    output logic           o_last_byte
);

    logic [7:0]  r_source_system;
    logic [7:0]  r_source_component;
    logic [7:0]  r_message_id;
    logic [7:0]  r_crc_extra;
    logic [7:0]  r_seq;
    logic [7:0]  r_frame_seq;
    logic [15:0] r_rx_err;
    logic [15:0] r_corr;
    logic [7:0]  r_lrssi;
    logic [7:0]  r_rrssi;
    logic [7:0]  r_txsp;
    logic [7:0]  r_lnoise;
    logic [7:0]  r_rnoise;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] crc_byte;
    logic [7:0]  cur_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_system    <= RST_SOURCE_SYSTEM;
            r_source_component <= RST_SOURCE_COMPONENT;
            r_message_id       <= RST_MESSAGE_ID;
            r_crc_extra        <= RST_CRC_EXTRA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_SYSTEM:    r_source_system    <= i_cfg_data;
                CFG_SOURCE_COMPONENT: r_source_component <= i_cfg_data;
                CFG_MESSAGE_ID:       r_message_id       <= i_cfg_data;
                CFG_CRC_EXTRA:        r_crc_extra        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= 8'd0;
        end else if (i_cmd.load) begin
            r_seq <= r_seq + 8'd1;
        end
    end

    // captured request, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame_seq <= r_seq;
            r_rx_err    <= i_rx_error_count;
            r_corr      <= i_corrected_count;
            r_lrssi     <= i_local_rssi;
            r_rrssi     <= i_remote_rssi;
            r_txsp      <= i_tx_space[7:0];
            r_lnoise    <= i_local_noise;
            r_rnoise    <= i_remote_noise;
        end
    end

    always_comb begin
        case (i_cmd.idx)
            IDX_START:  cur_byte = FRAME_START;
            IDX_LEN:    cur_byte = PAYLOAD_LEN;
            IDX_SEQ:    cur_byte = r_frame_seq;
            IDX_SYS:    cur_byte = r_source_system;
            IDX_COMP:   cur_byte = r_source_component;
            IDX_MSG:    cur_byte = r_message_id;
            IDX_RXE_LO: cur_byte = r_rx_err[7:0];
            IDX_RXE_HI: cur_byte = r_rx_err[15:8];
            IDX_COR_LO: cur_byte = r_corr[7:0];
            IDX_COR_HI: cur_byte = r_corr[15:8];
            IDX_LRSSI:  cur_byte = r_lrssi;
            IDX_RRSSI:  cur_byte = r_rrssi;
            IDX_TXSP:   cur_byte = r_txsp;
            IDX_LNOISE: cur_byte = r_lnoise;
            IDX_RNOISE: cur_byte = r_rnoise;
            IDX_CRC_LO: cur_byte = r_crc[7:0];
            IDX_CRC_HI: cur_byte = r_crc[15:8];
            default:    cur_byte = 8'h00;
        endcase
    end

    // checksum runs over bytes one to fourteen as they leave, seed folded after the last
    always_comb begin
        crc_byte = x25_step(r_crc, cur_byte);
        n_crc    = r_crc;
        if (i_cmd.advance) begin
            if (i_cmd.idx == IDX_RNOISE) begin
                n_crc = x25_step(crc_byte, r_crc_extra);
            end else if (i_cmd.idx >= IDX_LEN && i_cmd.idx < IDX_RNOISE) begin
                n_crc = crc_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_status.short_space = (i_tx_space < MIN_TX_SPACE);
    assign o_out_byte           = cur_byte;
    assign o_last_byte          = (i_cmd.idx == IDX_CRC_HI);

endmodule

>>> hw/rtl/rsfb_ctrl.sv
// rsfb_ctrl: state machine that accepts requests and steps the frame byte index
// depends on rsfb_pkg

module rsfb_ctrl
    import rsfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             req_xfer;
    logic             out_xfer;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);
    assign req_xfer    = i_req_valid && o_req_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer && !i_status.short_space) begin
                    n_state = ST_SEND;
                    n_idx   = IDX_START;
                end
            end
            ST_SEND: begin
                if (out_xfer) begin
                    if (r_idx == IDX_CRC_HI) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= IDX_START;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_cmd.load    = req_xfer;
    assign o_cmd.advance = out_xfer;
    assign o_cmd.idx     = r_idx;

`ifndef SYNTHESIS
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_idx == IDX_CRC_HI) |=> (o_req_ready && !o_out_valid))
        else $error("frame end did not return to idle");

    a_short_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && i_status.short_space) |=> (o_req_ready && !o_out_valid))
        else $error("short tx space request started a frame");

    a_frame_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && !i_status.short_space) |=> (o_out_valid && r_idx == IDX_START))
        else $error("frame did not start at the start byte");

    a_stall_holds_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_idx))
        else $error("byte index moved during stall");
`endif

endmodule

>>> hw/rtl/radio_status_frame_builder_top.sv
// radio_status_frame_builder_top: builds a 17-byte radio status frame with x25 checksum
// depends on rsfb_pkg, rsfb_if, rsfb_ctrl, rsfb_datapath
//
//  channel  dir  role                           payload
//  i_req    in   status request                 counters, rssi, noise, tx_space
//  o_frm    out  frame byte stream              out_byte, last_byte
//  i_cfg    in   config register write          index, data
//
// a request is accepted while idle, then its 17 bytes are transferred, one per cycle while
// o_frm is ready, set by the byte index counter that steps the frame and checksum
// a request is taken only between frames; a request with tx_space below 17 emits nothing
// and still advances the sequence number
// a stall on o_frm holds the current byte; synchronous active-low reset restores the
// register defaults and clears the sequence number; config writes are taken every cycle

module radio_status_frame_builder_top
    import rsfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    rsfb_req_if.sink    i_req,
    rsfb_byte_if.source o_frm,
    rsfb_cfg_if.sink    i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       req_ready;
    logic       out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;
    assign o_frm.valid = out_valid;

    rsfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_frm.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rsfb_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_rx_error_count  (i_req.rx_error_count),
        .i_corrected_count (i_req.corrected_count),
        .i_local_rssi      (i_req.local_rssi),
        .i_remote_rssi     (i_req.remote_rssi),
        .i_local_noise     (i_req.local_noise),
        .i_remote_noise    (i_req.remote_noise),
        .i_tx_space        (i_req.tx_space),
        .o_out_byte        (o_frm.out_byte),
        .o_last_byte       (o_frm.last_byte)
    );

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for radio_status_frame_builder_top
// predicts each 17-byte radio status frame and its x25 checksum, checks every byte transfer
// depends on rsfb_pkg, rsfb_if and the frame builder rtl

module tb_top
    import rsfb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 320;
    localparam int RANDOM_PHASES  = 4;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = CFG_CRC_EXTRA + 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LAST  = 8'hFF;

    typedef struct packed {
        logic [15:0] rx_error_count;
        logic [15:0] corrected_count;
        logic [7:0]  local_rssi;
        logic [7:0]  remote_rssi;
        logic [7:0]  local_noise;
        logic [7:0]  remote_noise;
        logic [15:0] tx_space;
    } t_status_req;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsfb_req_if  req_ch ();
    rsfb_byte_if frm_ch ();
    rsfb_cfg_if  cfg_ch ();

    radio_status_frame_builder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_frm   (frm_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    t_frame_byte frame_bytes_q[$];
    logic [7:0]  seq_num;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [7:0]  msg_id;
    logic [7:0]  crc_seed;
    int          mismatches   = 0;
    bit          throttle_on  = 1'b0;
    bit          running      = 1'b0;
    int          stall_left   = 0;
    int          quiet_cycles = 0;

    // reflected 0x1021 polynomial, one bit at a time
    function automatic logic [15:0] x25_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void predict_frame(input t_status_req r);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] crc;
        fb[0]  = FRAME_START;
        fb[1]  = PAYLOAD_LEN;
        fb[2]  = seq_num;
        fb[3]  = sys_id;
        fb[4]  = comp_id;
        fb[5]  = msg_id;
        fb[6]  = r.rx_error_count[7:0];
        fb[7]  = r.rx_error_count[15:8];
        fb[8]  = r.corrected_count[7:0];
        fb[9]  = r.corrected_count[15:8];
        fb[10] = r.local_rssi;
        fb[11] = r.remote_rssi;
        fb[12] = r.tx_space[7:0];
        fb[13] = r.local_noise;
        fb[14] = r.remote_noise;
        crc = CRC_INIT;
        for (int k = 1; k < 15; k++) begin
            crc = x25_fold(crc, fb[k]);
        end
        crc = x25_fold(crc, crc_seed);
        fb[15] = crc[7:0];
        fb[16] = crc[15:8];
        // sequence advances even when the frame is dropped
        seq_num = seq_num + 8'd1;
        if (r.tx_space >= MIN_TX_SPACE) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                frame_bytes_q.push_back('{data: fb[k], last: (k == FRAME_LEN - 1)});
            end
        end
    endfunction

    function automatic int rand_gap();
        int unsigned r;
        if (!throttle_on) return 0;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_status_req rand_req();
        t_status_req r;
        int unsigned sel;
        r.rx_error_count  = 16'($urandom);
        r.corrected_count = 16'($urandom);
        r.local_rssi      = 8'($urandom);
        r.remote_rssi     = 8'($urandom);
        r.local_noise     = 8'($urandom);
        r.remote_noise    = 8'($urandom);
        sel = $urandom_range(99);
        if (sel < 10)      r.tx_space = 16'($urandom_range(16));
        else if (sel < 15) r.tx_space = MIN_TX_SPACE;
        else if (sel < 40) r.tx_space = 16'($urandom_range(17, 600));
        else               r.tx_space = 16'($urandom_range(17, 65535));
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input logic [7:0] want,
                                            input logic [7:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("frame byte error at %0t: %s expected %02h got %02h", $realtime, what,
                     want, got);
        end
    endfunction

    task automatic send_request(input t_status_req r);
        int gap;
        req_ch.valid           <= 1'b1;
        req_ch.rx_error_count  <= r.rx_error_count;
        req_ch.corrected_count <= r.corrected_count;
        req_ch.local_rssi      <= r.local_rssi;
        req_ch.remote_rssi     <= r.remote_rssi;
        req_ch.local_noise     <= r.local_noise;
        req_ch.remote_noise    <= r.remote_noise;
        req_ch.tx_space        <= r.tx_space;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predict_frame(r);
        gap = rand_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        int gap;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_SOURCE_SYSTEM:    sys_id   = val;
            CFG_SOURCE_COMPONENT: comp_id  = val;
            CFG_MESSAGE_ID:       msg_id   = val;
            CFG_CRC_EXTRA:        crc_seed = val;
            default: ;
        endcase
        gap = rand_gap();
        if (gap > 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_registers(input logic [7:0] sys_v, input logic [7:0] comp_v,
                                 input logic [7:0] msg_v, input logic [7:0] seed_v);
        write_register(CFG_SOURCE_SYSTEM, sys_v);
        write_register(CFG_SOURCE_COMPONENT, comp_v);
        write_register(CFG_MESSAGE_ID, msg_v);
        write_register(CFG_CRC_EXTRA, seed_v);
        write_register(8'($urandom_range(CFG_UNMAPPED_FIRST, CFG_UNMAPPED_LAST)),
                       8'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // no frame outstanding, plus time for a dropped request to retire
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_request('{16'h1234, 16'h0056, 8'd200, 8'd180, 8'd40, 8'd35, 16'd1000});
        wait_idle();
    endtask

    task automatic test_field_extremes();
        send_request('{16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, MIN_TX_SPACE});
        send_request('{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        send_request('{16'hAAAA, 16'h5555, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'hAAAA});
        send_request('{16'h5555, 16'hAAAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 16'h5555});
        wait_idle();
    endtask

    task automatic test_short_space();
        t_status_req r;
        logic [15:0] spaces [7] = '{16'd0, 16'd16, 16'd17, 16'd255, 16'd256, 16'hFFFF, 16'd16};
        foreach (spaces[k]) begin
            r = rand_req();
            r.tx_space = spaces[k];
            send_request(r);
        end
        wait_idle();
    endtask

    task automatic test_register_writes();
        for (int k = CFG_SOURCE_SYSTEM; k <= CFG_CRC_EXTRA; k++) begin
            write_register(CFG_IDX_W'(k), 8'($urandom));
            cfg_ch.valid <= 1'b0;
            send_request(rand_req());
            wait_idle();
        end
        // writes outside the register map must leave the settings alone
        write_register(CFG_UNMAPPED_FIRST, 8'h00);
        write_register(CFG_UNMAPPED_LAST, 8'hFF);
        cfg_ch.valid <= 1'b0;
        send_request(rand_req());
        wait_idle();
    endtask

    // enough requests to wrap the sequence number
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            throttle_on = 1'b1;
            wait_idle();
            case (p)
                0:       set_registers(8'h00, 8'h00, 8'h00, 8'h00);
                1:       set_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: set_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            throttle_on = (p != 1);
            repeat (RANDOM_ITEMS / RANDOM_PHASES) send_request(rand_req());
        end
        throttle_on = 1'b1;
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && frm_ch.valid && frm_ch.ready) begin
            if (frame_bytes_q.size() == 0) begin
                report_mismatch("unexpected transfer", 8'h00, frm_ch.out_byte);
            end else begin
                want = frame_bytes_q.pop_front();
                if (frm_ch.out_byte !== want.data)
                    report_mismatch("out_byte", want.data, frm_ch.out_byte);
                if (frm_ch.last_byte !== want.last)
                    report_mismatch("last_byte", 8'(want.last), 8'(frm_ch.last_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (throttle_on && $urandom_range(3) == 0) begin
            stall_left = rand_gap();
            frm_ch.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end else begin
            frm_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if ((req_ch.valid && req_ch.ready) || (frm_ch.valid && frm_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("radio_status_frame_builder_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.rx_error_count  = '0;
        req_ch.corrected_count = '0;
        req_ch.local_rssi      = '0;
        req_ch.remote_rssi     = '0;
        req_ch.local_noise     = '0;
        req_ch.remote_noise    = '0;
        req_ch.tx_space        = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        frm_ch.ready           = 1'b0;
        seq_num  = 8'd0;
        sys_id   = RST_SOURCE_SYSTEM;
        comp_id  = RST_SOURCE_COMPONENT;
        msg_id   = RST_MESSAGE_ID;
        crc_seed = RST_CRC_EXTRA;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running     = 1'b1;
        throttle_on = 1'b1;

        test_reset_defaults();
        throttle_on = 1'b0;
        test_field_extremes();
        throttle_on = 1'b1;
        test_short_space();
        test_register_writes();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_bytes_q.size() == 0) begin
            $display("radio_status_frame_builder_top: match");
        end else begin
            $display("radio_status_frame_builder_top: mismatch");
        end
        $finish;
    end

endmodule

>>> radio_status_frame_builder_top.f
hw/rtl/rsfb_pkg.sv
hw/rtl/rsfb_if.sv
hw/rtl/rsfb_datapath.sv
hw/rtl/rsfb_ctrl.sv
hw/rtl/radio_status_frame_builder_top.sv
tb/tb_top.sv
